@@ sv/vtv_pkg.sv @@
// Package for the vertex transform / viewport block: field widths, register
// indexes and shared types. No dependencies.
package vtv_pkg;

   localparam int POS_W   = 24;
   localparam int COL_W   = 8;
   localparam int SCR_W   = 20;
   localparam int ROW_W   = 64;
   localparam int VP_W    = 16;
   localparam int CLIP_W  = 42;
   localparam int NUM_W   = 61;
   localparam int QUO_W   = 38;

   localparam logic [2:0] REG_ROW0   = 3'd0;
   localparam logic [2:0] REG_ROW1   = 3'd1;
   localparam logic [2:0] REG_ROW2   = 3'd2;
   localparam logic [2:0] REG_ROW3   = 3'd3;
   localparam logic [2:0] REG_LEFT   = 3'd4;
   localparam logic [2:0] REG_TOP    = 3'd5;
   localparam logic [2:0] REG_WIDTH  = 3'd6;
   localparam logic [2:0] REG_HEIGHT = 3'd7;

   localparam logic signed [SCR_W-1:0] SCR_MAX = 20'sh7FFFF;
   localparam logic signed [SCR_W-1:0] SCR_MIN = 20'sh80000;

   typedef struct packed {
      logic [COL_W-1:0] r;
      logic [COL_W-1:0] g;
      logic [COL_W-1:0] b;
      logic [COL_W-1:0] a;
   } color_type;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
      logic signed [POS_W-1:0] w;
      color_type               color;
   } vtx_type;

   typedef struct packed {
      logic signed [SCR_W-1:0] x;
      logic signed [SCR_W-1:0] y;
      color_type               color;
      logic                    w_zero;
   } scr_type;

   // viewport settings used by the transform scale stage and the output offset
   typedef struct packed {
      logic signed [VP_W-1:0] left;
      logic signed [VP_W-1:0] top;
      logic [VP_W-1:0]        width;
      logic [VP_W-1:0]        height;
   } vp_type;

endpackage

@@ sv/vtv_if.sv @@
// Valid/ready channel interface carrying one payload word.
// Payload type is a parameter; uses nothing from the package.
interface vtv_if #(parameter type T = logic) (input logic clock);
   logic valid;
   logic ready;
   T     data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ sv/vtv_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with stall.
// Widths set by parameters; carries a side payload alongside the quotient.
module vtv_div
   import vtv_pkg::*;
#(
   parameter int NW = 61,
   parameter int DW = 42,
   parameter int QW = 36,
   parameter int SW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QW-1:0] out_quo,
   output logic [SW-1:0] out_side
);
   // stage k holds remainder after producing quotient bits above QW-1-k
   logic [QW:0]         v_ff;
   logic [NW-1:0]       rem_ff [QW+1];
   logic [DW-1:0]       den_ff [QW+1];
   logic [QW-1:0]       quo_ff [QW+1];
   logic [SW-1:0]       side_ff[QW+1];

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (en) v_ff <= {v_ff[QW-1:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= in_num;
         den_ff[0]  <= in_den;
         quo_ff[0]  <= '0;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_st
      localparam int B = QW - 1 - k;
      logic [NW+QW:0] sub_in;
      logic [NW+QW:0] r_ext;
      always_comb begin
         r_ext  = {{(QW+1){1'b0}}, rem_ff[k]};
         sub_in = ({{(QW+1){1'b0}}, {{(NW-DW){1'b0}}, den_ff[k]}} << B);
      end
      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[k+1]  <= den_ff[k];
            side_ff[k+1] <= side_ff[k];
            if (r_ext >= sub_in) begin
               rem_ff[k+1] <= NW'(r_ext - sub_in);
               quo_ff[k+1] <= quo_ff[k] | (QW'(1) << B);
            end else begin
               rem_ff[k+1] <= rem_ff[k];
               quo_ff[k+1] <= quo_ff[k];
            end
         end
      end
   end

   assign out_valid = v_ff[QW];
   assign out_quo   = quo_ff[QW];
   assign out_side  = side_ff[QW];
endmodule

@@ sv/vtv_xform.sv @@
// Matrix transform front end: products, sums, and numerator setup.
// Uses vtv_pkg; feeds vtv_div through the top level.
module vtv_xform
   import vtv_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  vtx_type                   in_vtx,
   input  logic [ROW_W-1:0]          row0,
   input  logic [ROW_W-1:0]          row1,
   input  logic [ROW_W-1:0]          row3,
   input  vp_type                    vp,
   output logic                      out_valid,
   output logic [NUM_W-1:0]          num_x,
   output logic [NUM_W-1:0]          num_y,
   output logic [CLIP_W-1:0]         den,
   output logic                      neg_x,
   output logic                      neg_y,
   output logic                      wz,
   output logic                      cx_neg,
   output logic                      cy_neg,
   output color_type                 color
);
   // stage 1: 12 products, stage 2: sums, stage 3: add w, stage 4: scale,
   // stage 5: magnitudes
   logic [4:0] v_ff;
   logic signed [39:0] px_ff [4], py_ff [4], pw_ff [4];
   color_type c1_ff, c2_ff, c3_ff, c4_ff, c5_ff;
   logic signed [CLIP_W-1:0] cx_ff, cy_ff, cw_ff;
   logic signed [CLIP_W:0] sx_ff, sy_ff;
   logic signed [CLIP_W-1:0] cw3_ff, cw4_ff;
   logic cxn3_ff, cyn3_ff, cxn4_ff, cyn4_ff;
   logic signed [NUM_W:0] nx_ff, ny_ff;
   logic signed [POS_W-1:0] p [4];

   always_comb begin
      p[0] = in_vtx.x; p[1] = in_vtx.y; p[2] = in_vtx.z; p[3] = in_vtx.w;
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (en) v_ff <= {v_ff[3:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 4; c++) begin
            px_ff[c] <= $signed(row0[16*c +: 16]) * p[c];
            py_ff[c] <= $signed(row1[16*c +: 16]) * p[c];
            pw_ff[c] <= $signed(row3[16*c +: 16]) * p[c];
         end
         c1_ff <= in_vtx.color;
         cx_ff <= CLIP_W'(px_ff[0]) + CLIP_W'(px_ff[1]) + CLIP_W'(px_ff[2])
                  + CLIP_W'(px_ff[3]);
         cy_ff <= CLIP_W'(py_ff[0]) + CLIP_W'(py_ff[1]) + CLIP_W'(py_ff[2])
                  + CLIP_W'(py_ff[3]);
         cw_ff <= CLIP_W'(pw_ff[0]) + CLIP_W'(pw_ff[1]) + CLIP_W'(pw_ff[2])
                  + CLIP_W'(pw_ff[3]);
         c2_ff <= c1_ff;
         sx_ff  <= (CLIP_W+1)'(cx_ff) + (CLIP_W+1)'(cw_ff);
         sy_ff  <= (CLIP_W+1)'(cw_ff) - (CLIP_W+1)'(cy_ff);
         cw3_ff <= cw_ff;
         cxn3_ff <= cx_ff[CLIP_W-1];
         cyn3_ff <= cy_ff[CLIP_W-1];
         c3_ff <= c2_ff;
         // 8*size*sum: 43 x 17 signed product, fits in 62 bits
         nx_ff <= (NUM_W+1)'(sx_ff * $signed({1'b0, vp.width}) * 62'sd8);
         ny_ff <= (NUM_W+1)'(sy_ff * $signed({1'b0, vp.height}) * 62'sd8);
         cw4_ff  <= cw3_ff;
         cxn4_ff <= cxn3_ff;
         cyn4_ff <= cyn3_ff;
         c4_ff   <= c3_ff;
      end
   end

   // magnitudes of numerators with the half-divisor rounding term added later
   logic [NUM_W:0] ax, ay;
   always_comb begin
      ax = nx_ff[NUM_W] ? (NUM_W+1)'(-nx_ff) : nx_ff;
      ay = ny_ff[NUM_W] ? (NUM_W+1)'(-ny_ff) : ny_ff;
   end
   logic nxs_ff, nys_ff;
   logic [NUM_W-1:0] ax_ff, ay_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff  <= NUM_W'(ax);
         ay_ff  <= NUM_W'(ay);
         nxs_ff <= nx_ff[NUM_W] ^ cw4_ff[CLIP_W-1];
         nys_ff <= ny_ff[NUM_W] ^ cw4_ff[CLIP_W-1];
         wz     <= (cw4_ff == '0);
         cx_neg <= cxn4_ff;
         cy_neg <= cyn4_ff;
         den    <= cw4_ff[CLIP_W-1] ? CLIP_W'(-cw4_ff) : CLIP_W'(cw4_ff);
         c5_ff  <= c4_ff;
      end
   end

   assign out_valid = v_ff[4];
   assign num_x = ax_ff;
   assign num_y = ay_ff;
   assign neg_x = nxs_ff;
   assign neg_y = nys_ff;
   assign color = c5_ff;
endmodule

@@ sv/vertex_transform_viewport_top.sv @@
// Top level: config registers, transform front end, two dividers, rounding
// and saturation. Uses vtv_pkg, vtv_if, vtv_xform and vtv_div.
//
//   channel  | dir | contents
//   req      | in  | pos_x/y/z/w Q12.12, color r/g/b/a
//   rsp      | out | screen_x/y Q16.4, out r/g/b/a, w_zero
//   csr      | in  | index 0..7, 64-bit data, write only
//
// One word accepted per cycle unless stalled; the path holds 5 + 39 + 1 = 45
// register stages (5 transform stages, divider input register plus 38
// quotient-bit stages, output register). Synchronous active-high reset
// clears all valid bits and sets the config registers to defaults; data
// registers are not reset. The whole pipeline advances only when the output
// register is free or taken, so a stall holds every stage in place.
module vertex_transform_viewport_top
   import vtv_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   vtv_if.sink              req,
   vtv_if.source            rsp,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [ROW_W-1:0] csr_wdata
);
   localparam int QW = QUO_W;

   logic [ROW_W-1:0] row0_ff, row1_ff, row2_ff, row3_ff;
   vp_type vp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row0_ff <= 64'd4096;
         row1_ff <= 64'd268435456;
         row2_ff <= 64'd17592186044416;
         row3_ff <= 64'd1152921504606846976;
         vp_ff   <= '{left: '0, top: '0, width: 16'd640, height: 16'd480};
      end else if (csr_we) begin
         case (csr_index)
            REG_ROW0:   row0_ff <= csr_wdata;
            REG_ROW1:   row1_ff <= csr_wdata;
            REG_ROW2:   row2_ff <= csr_wdata;
            REG_ROW3:   row3_ff <= csr_wdata;
            REG_LEFT:   vp_ff.left   <= csr_wdata[VP_W-1:0];
            REG_TOP:    vp_ff.top    <= csr_wdata[VP_W-1:0];
            REG_WIDTH:  vp_ff.width  <= csr_wdata[VP_W-1:0];
            REG_HEIGHT: vp_ff.height <= csr_wdata[VP_W-1:0];
            default: ;
         endcase
      end
   end

   logic en, out_v_ff;
   scr_type out_ff;
   assign en = !out_v_ff || rsp.ready;
   assign req.ready = en;

   logic x_valid, neg_x, neg_y, wz, cxn, cyn;
   logic [NUM_W-1:0] num_x, num_y;
   logic [CLIP_W-1:0] den;
   color_type color;

   vtv_xform u_xform (
      .clock, .reset, .en,
      .in_valid (req.valid && en),
      .in_vtx   (req.data),
      .row0     (row0_ff), .row1 (row1_ff), .row3 (row3_ff),
      .vp       (vp_ff),
      .out_valid(x_valid),
      .num_x, .num_y, .den, .neg_x, .neg_y, .wz,
      .cx_neg (cxn), .cy_neg (cyn), .color
   );

   // rounding: q = (2n + d) / (2d); wz path substitutes den 1
   logic [NUM_W+1:0] nx2, ny2;
   logic [CLIP_W:0]  d2;
   always_comb begin
      d2  = wz ? (CLIP_W+1)'(2) : {den, 1'b0};
      nx2 = {1'b0, num_x, 1'b0} + (NUM_W+2)'(den);
      ny2 = {1'b0, num_y, 1'b0} + (NUM_W+2)'(den);
   end

   localparam int SW = 2 + 1 + 1 + 1 + $bits(color_type);
   logic dx_v, dy_v;
   logic [QW-1:0] qx, qy;
   logic [SW-1:0] sdx, sdy;

   vtv_div #(.NW(NUM_W+2), .DW(CLIP_W+1), .QW(QW), .SW(SW)) u_divx (
      .clock, .reset, .en, .in_valid(x_valid),
      .in_num(nx2), .in_den(d2), .in_side({neg_x, neg_y, wz, cxn, cyn, color}),
      .out_valid(dx_v), .out_quo(qx), .out_side(sdx)
   );
   vtv_div #(.NW(NUM_W+2), .DW(CLIP_W+1), .QW(QW), .SW(SW)) u_divy (
      .clock, .reset, .en, .in_valid(x_valid),
      .in_num(ny2), .in_den(d2), .in_side({neg_x, neg_y, wz, cxn, cyn, color}),
      .out_valid(dy_v), .out_quo(qy), .out_side(sdy)
   );

   // side: [SW-1]=neg_x [SW-2]=neg_y [SW-3]=wz [SW-4]=cx<0 [SW-5]=cy<0
   logic signed [QW+2:0] fx, fy;
   scr_type res;
   always_comb begin
      fx = (sdx[SW-1] ? -$signed({3'b0, qx}) : $signed({3'b0, qx}))
           + (QW+3)'($signed({vp_ff.left, 4'b0}));
      fy = (sdx[SW-2] ? -$signed({3'b0, qy}) : $signed({3'b0, qy}))
           + (QW+3)'($signed({vp_ff.top, 4'b0}));
      res.color = sdx[$bits(color_type)-1:0];
      res.w_zero = sdx[SW-3];
      if (sdx[SW-3]) begin
         res.x = sdx[SW-4] ? SCR_MIN : SCR_MAX;
         res.y = sdx[SW-5] ? SCR_MAX : SCR_MIN;
      end else begin
         res.x = (fx > (QW+3)'(SCR_MAX)) ? SCR_MAX :
                 (fx < (QW+3)'(SCR_MIN)) ? SCR_MIN : fx[SCR_W-1:0];
         res.y = (fy > (QW+3)'(SCR_MAX)) ? SCR_MAX :
                 (fy < (QW+3)'(SCR_MIN)) ? SCR_MIN : fy[SCR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (en) out_v_ff <= dx_v;
   end
   always_ff @(posedge clock) begin
      if (en) out_ff <= res;
   end

   assign rsp.valid = out_v_ff;
   assign rsp.data  = out_ff;

   a_div_lock: assert property (@(posedge clock) disable iff (reset) dx_v == dy_v)
      else $error("dividers out of step");
   a_side_lock: assert property (@(posedge clock) disable iff (reset)
      dx_v |-> sdx == sdy) else $error("divider side data mismatch");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !rsp.ready |=> out_v_ff && $stable(out_ff))
      else $error("output word changed under stall");
endmodule
